// ===== rtl/refcounted_node_cache_top_assert.svh =====
// Assertion macros used by the node cache top level.
`ifndef REFCOUNTED_NODE_CACHE_TOP_ASSERT_SVH
`define REFCOUNTED_NODE_CACHE_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define RNC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define RNC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rnc_pkg.sv =====
// Shared types, codes and constants of the reference-counted node cache.
package rnc_pkg;

  localparam int RNC_SLOTS = 64;

  localparam int KEY_W     = 64;
  localparam int HALF_W    = 32;
  localparam int CNT_W     = 16;
  localparam int KIND_W    = 2;
  localparam int STAT_W    = 3;
  localparam int IDX_OUT_W = 6;

  localparam int S_TDATA_W = 144;
  localparam int M_TDATA_W = 88;

  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = 1;
  localparam int QCNT_W  = 2;

  localparam logic [KIND_W-1:0] REQ_GET     = 2'd0;
  localparam logic [KIND_W-1:0] REQ_ENTER   = 2'd1;
  localparam logic [KIND_W-1:0] REQ_RELEASE = 2'd2;

  localparam logic [STAT_W-1:0] ST_HIT      = 3'd0;
  localparam logic [STAT_W-1:0] ST_NEW      = 3'd1;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd2;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd3;
  localparam logic [STAT_W-1:0] ST_EXCEED   = 3'd4;

  localparam logic [CNT_W-1:0] REF_MAX    = '1;
  localparam logic [CNT_W-1:0] REF_ONE    = 16'd1;
  localparam logic [KEY_W-1:0] ENTER_BIAS = 64'd2;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [KEY_W-1:0]  key;
    logic [CNT_W-1:0]  cnt;
  } rnc_req_t;

  typedef struct packed {
    logic clearing;
  } rnc_stat_t;

endpackage

// ===== rtl/rnc_front.sv =====
// Front end: accepts requests, forms the lookup key and queues them for the back end.
module rnc_front
  import rnc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [KIND_W-1:0] in_kind,
  input  logic [KEY_W-1:0]  in_number,
  input  logic [HALF_W-1:0] in_cluster,
  input  logic [HALF_W-1:0] in_offset,
  input  logic [CNT_W-1:0]  in_cnt,
  input  rnc_stat_t         back_stat,
  output logic              q_valid,
  input  logic              q_ready,
  output rnc_req_t          q_req
);

  rnc_req_t            q_mem [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  rnc_req_t            req_in;
  logic                push;
  logic                pop;

  // An enter request looks up the number built from its directory position.
  always_comb begin
    req_in.kind = in_kind;
    req_in.cnt  = in_cnt;
    if (in_kind == REQ_ENTER) begin
      req_in.key = {in_cluster, in_offset} + ENTER_BIAS;
    end else begin
      req_in.key = in_number;
    end
  end

  assign in_ready = !back_stat.clearing && (count != QCNT_W'(QDEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != '0);
  assign pop      = q_valid && q_ready;
  assign q_req    = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= req_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/rnc_back.sv =====
// Back end: scans the slot table one slot a cycle, writes back and holds the result word.
module rnc_back
  import rnc_pkg::*;
#(
  parameter int SLOTS = RNC_SLOTS
)
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  rnc_req_t             q_req,
  output rnc_stat_t            back_stat,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [STAT_W-1:0]    out_status,
  output logic [IDX_OUT_W-1:0] out_idx,
  output logic [KEY_W-1:0]     out_number,
  output logic [CNT_W-1:0]     out_refs
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_SCAN  = 5'b00100,
    S_DRAIN = 5'b01000,
    S_WRITE = 5'b10000
  } state_t;

  logic [KEY_W-1:0] key_mem  [SLOTS];
  logic [CNT_W-1:0] refs_mem [SLOTS];

  state_t           state;
  logic [IDX_W-1:0] addr;
  logic [KEY_W-1:0] key_rd;
  logic [CNT_W-1:0] refs_rd;
  logic             cmp_valid;
  logic [IDX_W-1:0] cmp_idx;
  rnc_req_t         cur;
  logic             hit_found;
  logic [IDX_W-1:0] hit_idx;
  logic [CNT_W-1:0] hit_refs;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;

  logic             out_free;
  logic             res_we;
  logic [IDX_W-1:0] res_widx;
  logic [CNT_W-1:0] res_wrefs;
  logic [STAT_W-1:0] res_status;
  logic [IDX_W-1:0] res_idx;
  logic [CNT_W-1:0] res_refs;
  logic [CNT_W-1:0] sat_refs;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [CNT_W-1:0] mem_wrefs;
  logic             slot_occ;

  assign out_free           = !out_valid || out_ready;
  assign q_ready            = (state == S_IDLE);
  assign back_stat.clearing = (state == S_CLEAR);
  assign slot_occ           = (refs_rd != '0);
  assign sat_refs           = (hit_refs == REF_MAX) ? hit_refs : hit_refs + 1'b1;

  // Outcome of the finished scan.
  always_comb begin
    res_we     = 1'b0;
    res_widx   = hit_idx;
    res_wrefs  = '0;
    res_status = ST_NOTFOUND;
    res_idx    = '0;
    res_refs   = '0;
    case (cur.kind)
      REQ_GET: begin
        if (hit_found) begin
          res_we     = 1'b1;
          res_wrefs  = sat_refs;
          res_status = ST_HIT;
          res_idx    = hit_idx;
          res_refs   = sat_refs;
        end
      end
      REQ_ENTER: begin
        if (hit_found) begin
          res_we     = 1'b1;
          res_wrefs  = sat_refs;
          res_status = ST_HIT;
          res_idx    = hit_idx;
          res_refs   = sat_refs;
        end else if (free_found) begin
          res_we     = 1'b1;
          res_widx   = free_idx;
          res_wrefs  = REF_ONE;
          res_status = ST_NEW;
          res_idx    = free_idx;
          res_refs   = REF_ONE;
        end else begin
          res_status = ST_FULL;
        end
      end
      REQ_RELEASE: begin
        if (hit_found) begin
          if (cur.cnt > hit_refs) begin
            res_status = ST_EXCEED;
            res_refs   = hit_refs;
          end else begin
            res_we     = 1'b1;
            res_wrefs  = hit_refs - cur.cnt;
            res_status = ST_HIT;
            res_idx    = hit_idx;
            res_refs   = hit_refs - cur.cnt;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // The clearing pass zeroes the counts; the key written alongside is unused.
  assign mem_we    = (state == S_CLEAR) || ((state == S_WRITE) && out_free && res_we);
  assign mem_waddr = (state == S_CLEAR) ? addr : res_widx;
  assign mem_wrefs = (state == S_CLEAR) ? '0 : res_wrefs;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      key_mem[mem_waddr]  <= cur.key;
      refs_mem[mem_waddr] <= mem_wrefs;
    end
    key_rd  <= key_mem[addr];
    refs_rd <= refs_mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      addr      <= '0;
      cmp_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if ((state == S_WRITE) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          if (addr == LAST_IDX) begin
            addr  <= '0;
            state <= S_IDLE;
          end else begin
            addr <= addr + 1'b1;
          end
        end
        S_IDLE: begin
          if (q_valid) begin
            addr      <= '0;
            cmp_valid <= 1'b0;
            state     <= S_SCAN;
          end
        end
        S_SCAN: begin
          cmp_valid <= 1'b1;
          if (addr == LAST_IDX) begin
            state <= S_DRAIN;
          end else begin
            addr <= addr + 1'b1;
          end
        end
        S_DRAIN: begin
          cmp_valid <= 1'b0;
          state     <= S_WRITE;
        end
        S_WRITE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_CLEAR;
          addr  <= '0;
        end
      endcase
    end
  end

  // Request capture, first-match and first-free search, result register.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && q_valid) begin
      cur        <= q_req;
      hit_found  <= 1'b0;
      free_found <= 1'b0;
    end
    if (state == S_SCAN) begin
      cmp_idx <= addr;
    end
    if (cmp_valid && (state == S_SCAN || state == S_DRAIN)) begin
      if (slot_occ && (key_rd == cur.key) && !hit_found) begin
        hit_found <= 1'b1;
        hit_idx   <= cmp_idx;
        hit_refs  <= refs_rd;
      end
      if (!slot_occ && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= cmp_idx;
      end
    end
    if (state == S_WRITE && out_free) begin
      out_status <= res_status;
      out_idx    <= IDX_OUT_W'(res_idx);
      out_number <= cur.key;
      out_refs   <= res_refs;
    end
  end

endmodule

// ===== rtl/refcounted_node_cache_top.sv =====
// A request's result word is loaded into the output register after a full scan of the slot table.
// The back end finishes one request before it takes the next; the table scan covers one slot per cycle.
// A two-word queue lets up to two requests be taken while the scan is busy.
// Reset (synchronous, active high) starts a clearing pass over the counts of all slots.
// No request is accepted during the clearing pass; s_tready stays low until it ends.
module refcounted_node_cache_top
  import rnc_pkg::*;
#(
  parameter int SLOTS = RNC_SLOTS
)
(
  input  logic                 clk,
  input  logic                 rst,
  // Request side.
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // Fields from bit 0: node_number[63:0], dir_cluster[95:64], dir_offset[127:96],
  // release_count[143:128].
  input  logic [S_TDATA_W-1:0] s_tdata,
  // Fields from bit 0: req_type[1:0].
  input  logic [KIND_W-1:0]    s_tuser,
  // Result side.
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // Fields from bit 0: slot_index[5:0], result_number[69:6], ref_count[85:70],
  // zero fill [87:86].
  output logic [M_TDATA_W-1:0] m_tdata,
  // Fields from bit 0: status[2:0].
  output logic [STAT_W-1:0]    m_tuser
);

  rnc_stat_t              back_stat;
  logic                   q_valid;
  logic                   q_ready;
  rnc_req_t               q_req;
  logic [IDX_OUT_W-1:0]   res_idx;
  logic [KEY_W-1:0]       res_number;
  logic [CNT_W-1:0]       res_refs;

  // The front end forms the lookup key (enter requests build it from the
  // directory position) and holds requests in a short queue, so input words
  // keep flowing while the back end is scanning.
  rnc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_kind    (s_tuser),
    .in_number  (s_tdata[63:0]),
    .in_cluster (s_tdata[95:64]),
    .in_offset  (s_tdata[127:96]),
    .in_cnt     (s_tdata[143:128]),
    .back_stat  (back_stat),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_req      (q_req)
  );

  // The back end walks the slot table once per request, records the first
  // matching occupied slot and the first free slot, then writes the updated
  // count back when there is one and loads the result word into its output register.
  rnc_back #(
    .SLOTS (SLOTS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_req      (q_req),
    .back_stat  (back_stat),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_status (m_tuser),
    .out_idx    (res_idx),
    .out_number (res_number),
    .out_refs   (res_refs)
  );

  assign m_tdata = {2'b00, res_refs, res_number, res_idx};

  // Checks on the result encoding and the reset sequence.
  `include "refcounted_node_cache_top_assert.svh"

  `RNC_ASSERT_IMPL(a_fail_no_slot,
    m_tvalid && (m_tuser == ST_NOTFOUND || m_tuser == ST_FULL || m_tuser == ST_EXCEED),
    m_tdata[5:0] == 6'd0, "failed request reports a slot index")
  `RNC_ASSERT_IMPL(a_new_one_ref, m_tvalid && (m_tuser == ST_NEW),
    m_tdata[85:70] == REF_ONE, "new slot does not hold exactly one reference")
  `RNC_ASSERT_IMPL(a_clear_blocks_input, back_stat.clearing, !s_tready,
    "request accepted during clearing pass")
  `RNC_ASSERT_NEXT(a_no_result_while_clearing, back_stat.clearing, !m_tvalid,
    "result word appeared during clearing pass")

endmodule
